// File: rtl/apsr_pkg.sv
// Shared types, codes and constants for the status-register transfer unit.
// No dependencies; imported by arm_psr_transfer_unit.
`default_nettype none

package apsr_pkg;

    localparam int REQ_W   = 3;
    localparam int WORD_W  = 32;
    localparam int BANKS   = 5;
    localparam int BANK_W  = 3;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 104;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_MSR_IMM     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MSR_REG     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MRS         = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SVC_ARM     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SVC_THUMB   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_UNDEF_ARM   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNDEF_THUMB = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXC_BASE  = 1'd1;

    localparam logic [BANK_W-1:0] BANK_FIQ = 3'd0;
    localparam logic [BANK_W-1:0] BANK_IRQ = 3'd1;
    localparam logic [BANK_W-1:0] BANK_SVC = 3'd2;
    localparam logic [BANK_W-1:0] BANK_ABT = 3'd3;
    localparam logic [BANK_W-1:0] BANK_UND = 3'd4;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;

    localparam logic [WORD_W-1:0] CPSR_RESET     = 32'h0000_00D3;
    localparam logic [WORD_W-1:0] ENTRY_UND_BITS = 32'h0000_009B;
    localparam logic [WORD_W-1:0] ENTRY_SVC_BITS = 32'h0000_0093;
    localparam logic [WORD_W-1:0] ENTRY_CLR_MASK = 32'h0000_00BF;
    localparam logic [WORD_W-1:0] FLAG_MASK_V5   = 32'hF800_0000;
    localparam logic [WORD_W-1:0] FLAG_MASK_V4   = 32'hF000_0000;
    localparam logic [WORD_W-1:0] FORCE_BIT4     = 32'h0000_0010;
    localparam logic [WORD_W-1:0] USER_MASK      = 32'hFFFF_FF00;
    localparam logic [WORD_W-1:0] CTRL_MASK      = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] VEC_SVC_OFS    = 32'h0000_0008;
    localparam logic [WORD_W-1:0] VEC_UND_OFS    = 32'h0000_0004;
    localparam logic [3:0]        LINK_REG       = 4'd14;
    localparam logic [3:0]        PC_REG         = 4'd15;

    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] idx;
    } bank_sel_t;

    function automatic bank_sel_t bank_of(input logic [4:0] mode);
        bank_sel_t sel;
        sel.valid = 1'b1;
        sel.idx   = BANK_FIQ;
        if (mode == MODE_FIQ)       sel.idx = BANK_FIQ;
        else if (mode == MODE_IRQ)  sel.idx = BANK_IRQ;
        else if (mode == MODE_SVC)  sel.idx = BANK_SVC;
        else if (mode[4:2] == 3'b101) sel.idx = BANK_ABT;
        else if (mode[4:2] == 3'b110) sel.idx = BANK_UND;
        else sel.valid = 1'b0;
        return sel;
    endfunction

endpackage

`default_nettype wire

// File: rtl/arm_psr_transfer_unit.sv
// Top level of the status-register transfer unit: CPSR, banked SPSRs, MSR/MRS
// and exception entry. Depends on apsr_pkg.
//
//  channel | ports                         | word
//  input   | s_tvalid s_tready s_tdata/user| instr, reg_value, pc_value / req_type
//  result  | m_tvalid m_tready m_tdata     | dest and jump fields, flags, cpsr_out
//  config  | cfg_valid cfg_ready           | cfg_index, cfg_data
//
// One word per cycle unless the result stalls; input register, then result register.
// The CPSR and SPSRs update as the result register loads, so the next word sees them.
// aresetn clears control state, the CPSR to 0xD3 and the SPSRs to zero.
// A stalled result holds; an empty input register still takes a word meanwhile.
`default_nettype none

module arm_psr_transfer_unit
    import apsr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // instr, reg_value, pc_value
    input  wire logic [REQ_W-1:0]     s_tuser,   // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // dest_write, dest_index, dest_value,
                                                 // jump, jump_target, mode_changed,
                                                 // thumb_entered, cpsr_out
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    logic              in_valid_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [WORD_W-1:0] instr_reg, rval_reg, pc_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              core_kind_reg;
    logic [WORD_W-1:0] exc_base_reg;
    logic [WORD_W-1:0] cpsr_reg, cpsr_next;
    logic [WORD_W-1:0] spsr_reg [BANKS];

    logic              out_free, fire;
    logic              spsr_we;
    logic [BANK_W-1:0] spsr_widx;
    logic [WORD_W-1:0] spsr_wdata;
    logic [OUT_W-1:0]  out_data_next;

    logic              dw, jmp, mc, te, use_spsr, is_svc, thumb;
    logic [3:0]        di, rd;
    logic [WORD_W-1:0] dv, jt, mask, val, psr, cur_spsr;
    logic [2*WORD_W-1:0] rot;
    bank_sel_t         bank;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        use_spsr   = instr_reg[22];
        bank       = bank_of(cpsr_reg[4:0]);
        cur_spsr   = spsr_reg[bank.idx];
        rd         = instr_reg[15:12];
        is_svc     = (req_reg == REQ_SVC_ARM) || (req_reg == REQ_SVC_THUMB);
        thumb      = (req_reg == REQ_SVC_THUMB) || (req_reg == REQ_UNDEF_THUMB);
        cpsr_next  = cpsr_reg;
        spsr_we    = 1'b0;
        spsr_widx  = bank.idx;
        spsr_wdata = cur_spsr;
        dw = 1'b0; di = '0; dv = '0; jmp = 1'b0; jt = '0; te = 1'b0;
        mask = '0;
        rot  = {24'd0, instr_reg[7:0], 24'd0, instr_reg[7:0]} >> {instr_reg[11:8], 1'b0};
        val  = (req_reg == REQ_MSR_IMM) ? rot[WORD_W-1:0] : rval_reg;
        val  = val | FORCE_BIT4;
        if (instr_reg[16]) mask = mask | CTRL_MASK;
        if (instr_reg[19]) mask = mask | (core_kind_reg ? FLAG_MASK_V4 : FLAG_MASK_V5);
        if (cpsr_reg[4:0] == MODE_USR) mask = mask & USER_MASK;
        psr = (use_spsr && bank.valid) ? cur_spsr : cpsr_reg;

        case (req_reg)
            REQ_MSR_IMM, REQ_MSR_REG: begin
                if (!(use_spsr && !bank.valid)) begin
                    if (use_spsr) begin
                        spsr_we    = 1'b1;
                        spsr_wdata = (cur_spsr & ~mask) | (val & mask);
                    end else begin
                        cpsr_next = (cpsr_reg & ~mask) | (val & mask);
                    end
                    if (cpsr_next[5]) begin
                        if (!core_kind_reg) te = 1'b1;
                        else cpsr_next[5] = 1'b0;
                    end
                end
            end
            REQ_MRS: begin
                if (rd == PC_REG) begin
                    if (core_kind_reg) begin
                        jmp = 1'b1;
                        jt  = {psr[WORD_W-1:1], 1'b0};
                    end
                end else begin
                    dw = 1'b1;
                    di = rd;
                    dv = psr;
                end
            end
            REQ_SVC_ARM, REQ_SVC_THUMB, REQ_UNDEF_ARM, REQ_UNDEF_THUMB: begin
                cpsr_next  = (cpsr_reg & ~ENTRY_CLR_MASK) |
                             (is_svc ? ENTRY_SVC_BITS : ENTRY_UND_BITS);
                spsr_we    = 1'b1;
                spsr_widx  = is_svc ? BANK_SVC : BANK_UND;
                spsr_wdata = cpsr_reg;
                dw  = 1'b1;
                di  = LINK_REG;
                dv  = pc_reg - (thumb ? 32'd2 : 32'd4);
                jmp = 1'b1;
                jt  = exc_base_reg + (is_svc ? VEC_SVC_OFS : VEC_UND_OFS);
            end
            default: begin
            end
        endcase

        mc = (cpsr_next[4:0] != cpsr_reg[4:0]);
        out_data_next = {cpsr_next, te, mc, jt, jmp, dv, di, dw};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            core_kind_reg <= 1'b0;
            exc_base_reg  <= '0;
            cpsr_reg      <= CPSR_RESET;
            for (int i = 0; i < BANKS; i++) spsr_reg[i] <= '0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (out_free) out_valid_reg <= in_valid_reg;
            if (fire) begin
                cpsr_reg <= cpsr_next;
                if (spsr_we) spsr_reg[spsr_widx] <= spsr_wdata;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_CORE_KIND: core_kind_reg <= cfg_data[0];
                    CFG_EXC_BASE:  exc_base_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg   <= s_tuser;
            instr_reg <= s_tdata[31:0];
            rval_reg  <= s_tdata[63:32];
            pc_reg    <= s_tdata[95:64];
        end
        if (fire) out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for arm_psr_transfer_unit: MSR, MRS and exception entry
// on the input stream, predicted results checked in order on the result stream.
// Depends on apsr_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;
    import apsr_pkg::*;

    localparam int             IDLE_PCT     = 22;
    localparam int             PIPE_LAT     = 2;
    localparam int             DRAIN_LIMIT  = 5000;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam logic [4:0]     MODE_ABT     = 5'h17;
    localparam logic [4:0]     MODE_ABT_ALT = 5'h14;
    localparam logic [4:0]     MODE_UND     = 5'h1B;
    localparam logic [4:0]     MODE_UND_ALT = 5'h18;
    localparam logic [4:0]     MODE_SYS     = 5'h1F;

    // last field in the lowest bits, matching the packing of m_tdata
    typedef struct packed {
        logic [31:0] cpsr_out;
        logic        thumb_entered;
        logic        mode_changed;
        logic [31:0] jump_target;
        logic        jump;
        logic [31:0] dest_value;
        logic [3:0]  dest_index;
        logic        dest_write;
    } psr_result_t;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [31:0]      instr;
        logic [31:0]      reg_value;
        logic [31:0]      pc_value;
    } psr_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    psr_result_t pending_results [$];
    int          fail_count  = 0;
    int          hold_cycles = 0;
    bit          quiet       = 1'b0;

    logic        arm7_rules;
    logic [31:0] vec_base;
    logic [31:0] psr_cur;
    logic [31:0] spsr_saved [BANKS];

    always #4 aclk = ~aclk;

    arm_psr_transfer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int spsr_slot(input logic [4:0] mode);
        if (mode == MODE_FIQ) return int'(BANK_FIQ);
        if (mode == MODE_IRQ) return int'(BANK_IRQ);
        if (mode == MODE_SVC) return int'(BANK_SVC);
        if (mode[4:2] == MODE_ABT[4:2]) return int'(BANK_ABT);
        if (mode[4:2] == MODE_UND[4:2]) return int'(BANK_UND);
        return -1;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] wide;
        wide = {v, v} >> n;
        return wide[31:0];
    endfunction

    function automatic psr_result_t exec_psr_op(input logic [REQ_W-1:0] req,
                                                input logic [31:0] instr,
                                                input logic [31:0] rval,
                                                input logic [31:0] pc);
        psr_result_t r;
        logic [31:0] prior;
        logic [31:0] mask;
        logic [31:0] val;
        logic [31:0] psr;
        logic [3:0]  rd;
        logic        spsr_sel;
        logic        svc;
        logic        thumb;
        int          slot;
        r        = '0;
        prior    = psr_cur;
        spsr_sel = instr[22];
        slot     = spsr_slot(psr_cur[4:0]);
        rd       = instr[15:12];
        case (req)
            REQ_MSR_IMM, REQ_MSR_REG: begin
                if (!(spsr_sel && slot < 0)) begin
                    mask = '0;
                    if (instr[16]) mask |= CTRL_MASK;
                    if (instr[19]) mask |= arm7_rules ? FLAG_MASK_V4 : FLAG_MASK_V5;
                    if (psr_cur[4:0] == MODE_USR) mask &= USER_MASK;
                    if (req == REQ_MSR_IMM)
                        val = ror32({24'h0, instr[7:0]}, {instr[11:8], 1'b0});
                    else val = rval;
                    val |= FORCE_BIT4;
                    if (spsr_sel) begin
                        spsr_saved[slot] = (spsr_saved[slot] & ~mask) | (val & mask);
                    end else begin
                        psr_cur = (psr_cur & ~mask) | (val & mask);
                        r.mode_changed = (prior[4:0] != psr_cur[4:0]);
                    end
                    if (psr_cur[5]) begin
                        if (!arm7_rules) r.thumb_entered = 1'b1;
                        else psr_cur[5] = 1'b0;
                    end
                end
            end
            REQ_MRS: begin
                psr = psr_cur;
                if (spsr_sel && slot >= 0) psr = spsr_saved[slot];
                if (rd == PC_REG) begin
                    if (arm7_rules) begin
                        r.jump        = 1'b1;
                        r.jump_target = {psr[31:1], 1'b0};
                    end
                end else begin
                    r.dest_write = 1'b1;
                    r.dest_index = rd;
                    r.dest_value = psr;
                end
            end
            REQ_SVC_ARM, REQ_SVC_THUMB, REQ_UNDEF_ARM, REQ_UNDEF_THUMB: begin
                svc   = (req == REQ_SVC_ARM || req == REQ_SVC_THUMB);
                thumb = (req == REQ_SVC_THUMB || req == REQ_UNDEF_THUMB);
                psr_cur = (psr_cur & ~ENTRY_CLR_MASK) | (svc ? ENTRY_SVC_BITS : ENTRY_UND_BITS);
                r.mode_changed = (prior[4:0] != psr_cur[4:0]);
                spsr_saved[svc ? BANK_SVC : BANK_UND] = prior;
                r.dest_write  = 1'b1;
                r.dest_index  = LINK_REG;
                r.dest_value  = pc - (thumb ? 32'd2 : 32'd4);
                r.jump        = 1'b1;
                r.jump_target = vec_base + (svc ? VEC_SVC_OFS : VEC_UND_OFS);
            end
            default: ;
        endcase
        r.cpsr_out = psr_cur;
        return r;
    endfunction

    function automatic logic [31:0] msr_instr(input logic spsr, input logic ctrl,
                                              input logic flags, input logic [3:0] rot,
                                              input logic [7:0] imm);
        return {9'b0, spsr, 2'b0, flags, 2'b0, ctrl, 4'b0, rot, imm};
    endfunction

    function automatic logic [31:0] mrs_instr(input logic spsr, input logic [3:0] rd);
        return {9'b0, spsr, 6'b0, rd, 12'b0};
    endfunction

    function automatic psr_word_t random_word();
        psr_word_t w;
        int        pick;
        pick        = $urandom_range(99);
        w.instr     = $urandom;
        w.reg_value = $urandom;
        w.pc_value  = $urandom;
        if (pick < 30)      w.req = REQ_MSR_IMM;
        else if (pick < 58) w.req = REQ_MSR_REG;
        else if (pick < 82) w.req = REQ_MRS;
        else if (pick < 86) w.req = REQ_SVC_ARM;
        else if (pick < 90) w.req = REQ_SVC_THUMB;
        else if (pick < 94) w.req = REQ_UNDEF_ARM;
        else if (pick < 98) w.req = REQ_UNDEF_THUMB;
        else                w.req = REQ_UNUSED;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    task automatic issue_word(input logic [REQ_W-1:0] req, input logic [31:0] instr,
                              input logic [31:0] rval, input logic [31:0] pc);
        psr_result_t want;
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pc, rval, instr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = exec_psr_op(req, instr, rval, pc);
        pending_results.push_back(want);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_CORE_KIND) arm7_rules = data[0];
        else vec_base = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic kind, input logic [31:0] base);
        wait_drain();
        write_reg(CFG_CORE_KIND, {31'b0, kind});
        write_reg(CFG_EXC_BASE, base);
    endtask

    // reset configuration: ARM9 rules, vectors at zero, supervisor mode
    task automatic t_psr_directed();
        issue_word(REQ_MRS, mrs_instr(1'b0, 4'd0), '0, '0);
        issue_word(REQ_MRS, mrs_instr(1'b1, LINK_REG), '0, '0);
        issue_word(REQ_MSR_IMM, msr_instr(1'b1, 1'b1, 1'b1, 4'h4, 8'hF1), '0, '0);
        issue_word(REQ_MRS, mrs_instr(1'b1, 4'd3), '0, '0);
        issue_word(REQ_MSR_IMM, msr_instr(1'b0, 1'b1, 1'b1, 4'hF, 8'hFF), '0, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b1, 1'b1, 1'b1, 4'h0, 8'h00), '1, '0);
        issue_word(REQ_MRS, mrs_instr(1'b1, PC_REG), '0, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b0, 1'b1, 1'b1, 4'h0, 8'h00),
                   {24'hFF_FFFF, 3'b110, MODE_ABT}, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b1, 1'b1, 1'b1, 4'h0, 8'h00), '1, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b0, 1'b1, 1'b0, 4'h0, 8'h00),
                   {27'h0, MODE_ABT_ALT}, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b0, 1'b1, 1'b0, 4'h0, 8'h00),
                   {27'h0, MODE_UND_ALT}, '0);
        issue_word(REQ_MRS, mrs_instr(1'b1, 4'd7), '0, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b0, 1'b1, 1'b0, 4'h0, 8'h00),
                   {27'h0, MODE_USR}, '0);
        issue_word(REQ_MSR_IMM, msr_instr(1'b0, 1'b1, 1'b1, 4'h0, 8'h1F), '0, '0);
        issue_word(REQ_MRS, mrs_instr(1'b1, 4'd9), '0, '0);
        issue_word(REQ_SVC_ARM, '1, '0, 32'h0000_0000);
        issue_word(REQ_UNDEF_THUMB, '0, '1, 32'hFFFF_FFFF);
        issue_word(REQ_SVC_THUMB, '0, '0, 32'h0000_0002);
        issue_word(REQ_UNDEF_ARM, $urandom, $urandom, $urandom);
        issue_word(REQ_UNUSED, '1, '1, '1);
    endtask

    task automatic t_arm7_directed();
        configure(1'b1, 32'hFFFF_FFFF);
        issue_word(REQ_MRS, mrs_instr(1'b0, PC_REG), '0, '0);
        issue_word(REQ_MRS, mrs_instr(1'b1, PC_REG), '0, '0);
        issue_word(REQ_MSR_REG, msr_instr(1'b0, 1'b1, 1'b1, 4'h0, 8'h00),
                   {24'hFF_FFFF, 3'b001, MODE_SYS}, '0);
        issue_word(REQ_SVC_ARM, '0, '0, 32'h0000_0004);
        issue_word(REQ_UNDEF_THUMB, '0, '0, 32'h8000_0000);
        issue_word(REQ_MSR_IMM, msr_instr(1'b1, 1'b1, 1'b1, 4'h1, 8'hBC), '0, '0);
    endtask

    task automatic t_random_mix(input logic kind, input logic [31:0] base,
                                input int count, input bit calm);
        psr_word_t w;
        configure(kind, base);
        quiet = calm;
        repeat (count) begin
            w = random_word();
            issue_word(w.req, w.instr, w.reg_value, w.pc_value);
        end
        quiet = 1'b0;
    endtask

    // hold the result side long enough for the block to back up into its input
    task automatic t_input_stall();
        psr_word_t w;
        configure(1'($urandom_range(1)), $urandom);
        hold_cycles = 150;
        repeat (80) begin
            w = random_word();
            issue_word(w.req, w.instr, w.reg_value, w.pc_value);
        end
    endtask

    always @(posedge aclk) begin : result_check
        psr_result_t got;
        psr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, cpsr_out", got.cpsr_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.dest_write !== want.dest_write)
                    report_mismatch("dest_write", 32'(got.dest_write),
                                    32'(want.dest_write));
                if (got.dest_index !== want.dest_index)
                    report_mismatch("dest_index", 32'(got.dest_index),
                                    32'(want.dest_index));
                if (got.dest_value !== want.dest_value)
                    report_mismatch("dest_value", got.dest_value, want.dest_value);
                if (got.jump !== want.jump)
                    report_mismatch("jump", 32'(got.jump), 32'(want.jump));
                if (got.jump_target !== want.jump_target)
                    report_mismatch("jump_target", got.jump_target, want.jump_target);
                if (got.mode_changed !== want.mode_changed)
                    report_mismatch("mode_changed", 32'(got.mode_changed),
                                    32'(want.mode_changed));
                if (got.thumb_entered !== want.thumb_entered)
                    report_mismatch("thumb_entered", 32'(got.thumb_entered),
                                    32'(want.thumb_entered));
                if (got.cpsr_out !== want.cpsr_out)
                    report_mismatch("cpsr_out", got.cpsr_out, want.cpsr_out);
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        arm7_rules = 1'b0;
        vec_base   = '0;
        psr_cur    = CPSR_RESET;
        foreach (spsr_saved[i]) spsr_saved[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        t_psr_directed();
        t_arm7_directed();
        t_random_mix(1'b0, 32'h0000_0000, 260, 1'b1);
        t_random_mix(1'b1, 32'hFFFF_0000, 260, 1'b0);
        t_input_stall();
        t_random_mix(1'b0, 32'hFFFF_FFFF, 260, 1'b0);
        t_random_mix(1'b1, $urandom, 260, 1'b0);
        t_random_mix(1'b0, $urandom, 260, 1'b0);

        wait_drain();
        if (pending_results.size() != 0)
            report_mismatch("words never returned", pending_results.size(), '0);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
